>>> rtl/dit_pkg.sv
package dit_pkg;

	// counter width of the interval and elapsed registers
	localparam int COUNT_WIDTH = 32;

	localparam int CMD_WIDTH   = 3;
	localparam int BYTE_WIDTH  = 8;

	// bus commands
	localparam logic [CMD_WIDTH-1:0] CMD_TICK     = 3'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_RD_DATA  = 3'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_WR_DATA  = 3'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_RD_CTRL  = 3'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_WR_CTRL  = 3'd4;

	// control and data port codes
	localparam logic [BYTE_WIDTH-1:0] ENABLE_CODE = 8'h3D;
	localparam int                    STOP_BIT    = 7;
	localparam logic [3:0]            NIB_STOP_C  = 4'hC;
	localparam logic [3:0]            NIB_STOP_D  = 4'hD;
	localparam logic [3:0]            NIB_STOP_F  = 4'hF;

	// one bus request as seen by the timer core
	typedef struct packed {
		logic [CMD_WIDTH-1:0]  cmd;
		logic [BYTE_WIDTH-1:0] wdata;
	} dit_req_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// interval in microseconds by the low nibble: decades 1 us to 100 s, then 1 min, 1 h, 10 min, 20 ms
	function automatic count_t interval_lookup(input logic [3:0] nib);
		logic [63:0] us;
		begin
			case (nib)
				4'h0: us = 64'd1;
				4'h1: us = 64'd10;
				4'h2: us = 64'd100;
				4'h3: us = 64'd1000;
				4'h4: us = 64'd10 * 64'd1000;
				4'h5: us = 64'd100 * 64'd1000;
				4'h6: us = 64'd1000 * 64'd1000;
				4'h7: us = 64'd10 * 64'd1000 * 64'd1000;
				4'h8: us = 64'd100 * 64'd1000 * 64'd1000;
				4'h9: us = 64'd60 * 64'd1000 * 64'd1000;
				4'hA: us = 64'd60 * 64'd60 * 64'd1000 * 64'd1000;
				4'hB: us = 64'd10 * 64'd60 * 64'd1000 * 64'd1000;
				4'hE: us = 64'd20 * 64'd1000;
				default: us = 64'd0;
			endcase
			interval_lookup = us[COUNT_WIDTH-1:0];
		end
	endfunction

endpackage

>>> rtl/dit_core.sv
module dit_core
	import dit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  dit_req_t req,
	output logic     irq_next
);

	logic   enabled_q, running_q, irq_q;
	count_t interval_q, elapsed_q;

	logic   enabled_n, running_n, irq_n;
	count_t interval_n, elapsed_n;
	count_t elapsed_inc;
	logic   stop_req;
	logic [3:0] nib;

	assign nib         = req.wdata[3:0];
	assign elapsed_inc = elapsed_q + count_t'(1);
	assign stop_req    = req.wdata[STOP_BIT] || (nib == NIB_STOP_C) ||
	                     (nib == NIB_STOP_D) || (nib == NIB_STOP_F);

	// next timer state for the current request
	always_comb begin
		enabled_n  = enabled_q;
		running_n  = running_q;
		irq_n      = irq_q;
		interval_n = interval_q;
		elapsed_n  = elapsed_q;
		case (req.cmd)
			CMD_TICK: begin
				if (running_q) begin
					if (elapsed_inc >= interval_q) begin
						irq_n     = 1'b1;
						elapsed_n = '0;
					end else begin
						elapsed_n = elapsed_inc;
					end
				end
			end
			CMD_RD_DATA: begin
				irq_n = 1'b0;
			end
			CMD_WR_DATA: begin
				if (enabled_q) begin
					if (stop_req) begin
						running_n = 1'b0;
					end else begin
						interval_n = interval_lookup(nib);
						elapsed_n  = '0;
						running_n  = 1'b1;
					end
				end
			end
			CMD_WR_CTRL: begin
				enabled_n = (req.wdata == ENABLE_CODE);
			end
			default: begin
			end
		endcase
	end

	assign irq_next = irq_n;

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			running_q  <= 1'b0;
			irq_q      <= 1'b0;
			interval_q <= '0;
			elapsed_q  <= '0;
		end else if (fire) begin
			enabled_q  <= enabled_n;
			running_q  <= running_n;
			irq_q      <= irq_n;
			interval_q <= interval_n;
			elapsed_q  <= elapsed_n;
		end
	end

endmodule

>>> rtl/decade_interval_timer.sv
// decade interval timer behind a data port and a control port
// slave channel: one bus request per item; s_tuser carries the command
// (tick, read data, write data, read control, write control), s_tdata the
// byte written on port writes
// master channel: one result per request; m_tdata carries the read byte
// (always zero) and the interrupt pending level after that request
// a request passes the input register and then the result register before
// its result shows on the master side; the timer state is updated in the
// same pass, so one request per cycle is sustained while the receiver
// takes results, limited by the single add and compare of the elapsed count
// when the receiver stalls, the result register holds and the input
// register fills, after which s_tready drops until the result is taken
// reset clears the enable, run and interrupt flags, the interval and the
// elapsed count, and empties both registers
module decade_interval_timer
	import dit_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_WIDTH-1:0] s_tdata,   // [7:0] wdata
	input  logic [CMD_WIDTH-1:0]  s_tuser,   // [2:0] cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata    // [7:0] rdata, [8] irq, [15:9] zero
);

	logic     valid_s1;
	dit_req_t req_s1;
	logic     valid_s2;
	logic     irq_s2;
	logic     advance;
	logic     fire;
	logic     irq_next;

	// result register can take a new value when empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd   <= s_tuser;
			req_s1.wdata <= s_tdata;
		end
	end

	dit_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req      (req_s1),
		.irq_next (irq_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			irq_s2 <= irq_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, irq_s2, 8'd0};

endmodule
